FILE: rtl/log_token_bucket_limiter_top_assert.svh
// Assertion macros used by the checker module of the log token bucket limiter.
// Depends on nothing; included by the checker file.
`ifndef LOG_TOKEN_BUCKET_LIMITER_TOP_ASSERT_SVH
`define LOG_TOKEN_BUCKET_LIMITER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ltb assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ltb assertion failed");

`endif

FILE: rtl/ltb_pkg.sv
// Package for the log token bucket limiter: sequencer states, register indexes,
// reset values and the status struct of the divider. No dependencies.
`default_nettype none

package ltb_pkg;

  localparam int LEVEL_W = 3;
  localparam int TOKEN_W = 8;
  localparam int IVAL_W  = 16;
  localparam int SUPP_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_VERBOSITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_SIZE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_INTERVAL = 2'd2;

  localparam logic [LEVEL_W-1:0] MIN_VERBOSITY_RST   = 3'd2;
  localparam logic [TOKEN_W-1:0] BURST_SIZE_RST      = 8'd10;
  localparam logic [IVAL_W-1:0]  REFILL_INTERVAL_RST = 16'd1000;

  localparam logic [SUPP_W-1:0] SUPP_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH,
    ST_OUT
  } ltb_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ltb_div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/log_token_bucket_limiter_top.sv
// Log event token bucket limiter: top level with the sequencer, bucket state and
// configuration registers. Depends on ltb_pkg and ltb_div.
//
// Usage: an event transaction carries now_ms and level on the input channel
// (in_valid, in_stall); one result transaction (pass, level_filtered,
// suppressed_before) leaves on the output channel (out_valid, out_stall) for
// every event. The block handles one event at a time and holds in_stall high
// from acceptance until its result has been taken.
// Sequence: an event dropped by the level filter goes from the check state to the
// output state; an event whose time is past the stored time runs the bit-serial
// divider, one time bit per cycle, then the update and finish states. Other events
// go from the check state through the finish state to the output state.
// While out_stall is high the result holds steady and no new event is taken.
// Reset (synchronous, active high) restores the register defaults (verbosity 2,
// burst 10, interval 1000 ms), empties the bucket, clears the suppressed count
// and marks the stored time as not yet started. Configuration writes through
// cfg_we, cfg_index and cfg_data take effect at once and belong only to idle
// periods; index 3 is ignored and an interval of zero acts as one.
`default_nettype none

module log_token_bucket_limiter_top #(
  parameter int TIME_BITS = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ltb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ltb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [TIME_BITS-1:0]          now_ms,
  input  wire logic [ltb_pkg::LEVEL_W-1:0]   level,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               pass,
  output logic                               level_filtered,
  output logic [ltb_pkg::SUPP_W-1:0]         suppressed_before
);
  import ltb_pkg::*;

  ltb_state_t state;
  ltb_state_t state_next;

  logic [LEVEL_W-1:0]  min_verbosity;
  logic [TOKEN_W-1:0]  burst_size;
  logic [IVAL_W-1:0]   refill_interval;

  logic [TIME_BITS-1:0] last_refill_ms;
  logic [TOKEN_W-1:0]   token_count;
  logic [SUPP_W-1:0]    suppressed_count;

  logic [TIME_BITS-1:0] now_q;
  logic [LEVEL_W-1:0]   level_q;

  logic [TIME_BITS:0]   elapsed;
  logic                 time_advanced;
  logic                 filtered;
  logic                 div_start;
  logic [IVAL_W-1:0]    ival;
  logic [TOKEN_W:0]     token_sum;
  logic                 gain_large;

  ltb_div_stat_t        div_stat;
  logic [TIME_BITS-1:0] quotient;
  logic [IVAL_W-1:0]    remainder;

  always_comb begin
    elapsed       = {1'b0, now_q} - {1'b0, last_refill_ms};
    time_advanced = !elapsed[TIME_BITS] && (elapsed[TIME_BITS-1:0] != '0);
    filtered      = level_q > min_verbosity;
    ival          = (refill_interval == '0) ? IVAL_W'(1) : refill_interval;
    token_sum     = {1'b0, token_count} + {1'b0, quotient[TOKEN_W-1:0]};
    gain_large    = |quotient[TIME_BITS-1:TOKEN_W];
  end

  ltb_div #(
    .W (TIME_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (elapsed[TIME_BITS-1:0]),
    .divisor   (ival),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (filtered) begin
          state_next = ST_OUT;
        end else if (last_refill_ms == '0 || !time_advanced) begin
          state_next = ST_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_FINISH;
      ST_FINISH: state_next = ST_OUT;
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_verbosity   <= MIN_VERBOSITY_RST;
      burst_size      <= BURST_SIZE_RST;
      refill_interval <= REFILL_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_VERBOSITY:   min_verbosity   <= cfg_data[LEVEL_W-1:0];
        REG_BURST_SIZE:      burst_size      <= cfg_data[TOKEN_W-1:0];
        REG_REFILL_INTERVAL: refill_interval <= cfg_data[IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_refill_ms   <= '0;
      token_count      <= '0;
      suppressed_count <= '0;
    end else begin
      case (state)
        ST_CHECK: begin
          if (!filtered && last_refill_ms == '0) begin
            last_refill_ms <= now_q;
            token_count    <= burst_size;
          end
        end
        ST_UPDATE: begin
          if (quotient != '0) begin
            last_refill_ms <= now_q - TIME_BITS'(remainder);
            if (gain_large || token_sum >= {1'b0, burst_size}) begin
              token_count <= burst_size;
            end else begin
              token_count <= token_sum[TOKEN_W-1:0];
            end
          end
        end
        ST_FINISH: begin
          if (token_count == '0) begin
            if (suppressed_count != SUPP_MAX) begin
              suppressed_count <= suppressed_count + SUPP_W'(1);
            end
          end else begin
            token_count      <= token_count - TOKEN_W'(1);
            suppressed_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      now_q   <= now_ms;
      level_q <= level;
    end
    if (state == ST_CHECK && filtered) begin
      pass              <= 1'b0;
      level_filtered    <= 1'b1;
      suppressed_before <= '0;
    end
    if (state == ST_FINISH) begin
      level_filtered <= 1'b0;
      if (token_count == '0) begin
        pass              <= 1'b0;
        suppressed_before <= '0;
      end else begin
        pass              <= 1'b1;
        suppressed_before <= suppressed_count;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ltb_div.sv
// Bit-serial restoring divider: a W-bit dividend by a 16-bit divisor, one bit per cycle.
// Depends on ltb_pkg for widths and the status struct.
`default_nettype none

module ltb_div #(
  parameter int W = 48
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [W-1:0]             dividend,
  input  wire logic [ltb_pkg::IVAL_W-1:0] divisor,
  output ltb_pkg::ltb_div_stat_t        stat,
  output logic [W-1:0]                  quotient,
  output logic [ltb_pkg::IVAL_W-1:0]    remainder
);
  import ltb_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]      dvd;
  logic [IVAL_W-1:0] rem;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;

  logic [IVAL_W:0]   shifted;
  logic [IVAL_W:0]   diff;
  logic              ge;

  always_comb begin
    shifted = {rem, dvd[W-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[W-2:0], ge};
      rem <= ge ? diff[IVAL_W-1:0] : shifted[IVAL_W-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;
  assign remainder = rem;

endmodule

`default_nettype wire

FILE: rtl/ltb_checker.sv
// Port-level checker for the log token bucket limiter, bound to the top level.
// Depends on the assertion macros in log_token_bucket_limiter_top_assert.svh.
`default_nettype none

`include "log_token_bucket_limiter_top_assert.svh"

module ltb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        pass,
  input wire logic        level_filtered,
  input wire logic [31:0] suppressed_before
);

  `LTB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pass) && $stable(level_filtered) && $stable(suppressed_before))

  `LTB_ASSERT_SAME(a_pass_not_filtered, clk, rst, out_valid && pass, !level_filtered)

  `LTB_ASSERT_SAME(a_no_count_on_drop, clk, rst, out_valid && !pass, suppressed_before == 32'd0)

  `LTB_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall && !out_valid)

  `LTB_ASSERT_SAME(a_no_accept_with_result, clk, rst, out_valid, in_stall)

endmodule

bind log_token_bucket_limiter_top ltb_checker u_ltb_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .pass              (pass),
  .level_filtered    (level_filtered),
  .suppressed_before (suppressed_before)
);

`default_nettype wire

FILE: tb/tb_log_token_bucket_limiter_top.sv
// Testbench for log_token_bucket_limiter_top: directed and random event traffic under
// several idling patterns, each result checked against an internal token bucket predictor.
// Depends on ltb_pkg and the RTL of the limiter.
module tb_log_token_bucket_limiter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ltb_pkg::*;

  localparam int TW = 48;
  localparam logic [TW-1:0] TIME_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic              pass;
    logic              filtered;
    logic [SUPP_W-1:0] supp;
  } event_verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [TW-1:0] now_ms = '0;
  logic [LEVEL_W-1:0] level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic pass;
  logic level_filtered;
  logic [SUPP_W-1:0] suppressed_before;

  // Predictor copy of the registers and the bucket.
  logic [LEVEL_W-1:0] shadow_verb = MIN_VERBOSITY_RST;
  logic [TOKEN_W-1:0] shadow_burst = BURST_SIZE_RST;
  logic [IVAL_W-1:0] shadow_ival = REFILL_INTERVAL_RST;
  logic [TW-1:0] bucket_last_ms = '0;
  logic [TOKEN_W-1:0] bucket_tokens = '0;
  logic [SUPP_W-1:0] bucket_suppressed = '0;

  event_verdict_t pending_verdicts[$];
  int err_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  log_token_bucket_limiter_top u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now_ms(now_ms),
    .level(level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pass(pass),
    .level_filtered(level_filtered),
    .suppressed_before(suppressed_before)
  );

  always #1ns clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic bucket_predict(input logic [TW-1:0] t, input logic [LEVEL_W-1:0] lv);
    event_verdict_t v;
    logic [63:0] ival;
    logic [63:0] gained;
    logic [63:0] total;
    v = '0;
    ival = (shadow_ival == '0) ? 64'd1 : 64'(shadow_ival);
    if (lv > shadow_verb) begin
      v.filtered = 1'b1;
    end else begin
      if (bucket_last_ms == '0) begin
        bucket_last_ms = t;
        bucket_tokens = shadow_burst;
      end else if (t > bucket_last_ms) begin
        gained = (64'(t) - 64'(bucket_last_ms)) / ival;
        if (gained != 0) begin
          total = 64'(bucket_tokens) + gained;
          bucket_last_ms = bucket_last_ms + TW'(gained * ival);
          bucket_tokens = (total < 64'(shadow_burst)) ? total[TOKEN_W-1:0] : shadow_burst;
        end
      end
      if (bucket_tokens == '0) begin
        if (bucket_suppressed != SUPP_MAX) bucket_suppressed++;
      end else begin
        bucket_tokens--;
        v.pass = 1'b1;
        v.supp = bucket_suppressed;
        bucket_suppressed = '0;
      end
    end
    pending_verdicts.push_back(v);
  endtask

  // Check every result transaction against the oldest pending verdict.
  always @(posedge clk) begin
    event_verdict_t got;
    event_verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{pass, level_filtered, suppressed_before};
      if (pending_verdicts.size() == 0) begin
        report_error($sformatf("result with nothing pending: pass %0b filtered %0b supp %0d",
                               got.pass, got.filtered, got.supp));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.pass !== want.pass)
          report_error($sformatf("pass: got %0b, want %0b", got.pass, want.pass));
        if (got.filtered !== want.filtered)
          report_error($sformatf("level_filtered: got %0b, want %0b",
                                 got.filtered, want.filtered));
        if (got.supp !== want.supp)
          report_error($sformatf("suppressed_before: got %0d, want %0d", got.supp, want.supp));
      end
    end
  end

  task automatic send_event(input logic [TW-1:0] t, input logic [LEVEL_W-1:0] lv);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms <= t;
    level <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bucket_predict(t, lv);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MIN_VERBOSITY:   shadow_verb = data[LEVEL_W-1:0];
      REG_BURST_SIZE:      shadow_burst = data[TOKEN_W-1:0];
      REG_REFILL_INTERVAL: shadow_ival = data[IVAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [LEVEL_W-1:0] verb, input logic [TOKEN_W-1:0] burst,
                            input logic [IVAL_W-1:0] ival);
    wait_drained();
    write_reg(REG_MIN_VERBOSITY, {13'($urandom), verb});
    write_reg(REG_BURST_SIZE, {8'($urandom), burst});
    write_reg(REG_REFILL_INTERVAL, ival);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
      default: begin src_idle_pct = 32; sink_stall_pct = 32; end
    endcase
  endtask

  // Reset defaults, a first event at time zero and the restart that follows it.
  task automatic test_first_event();
    send_event(48'd0, 3'd0);
    send_event(48'd0, 3'd3);
    send_event(TIME_MAX, 3'd7);
    send_event(48'd5, 3'd2);
    send_event(48'd1004, 3'd1);
    send_event(48'd1005, 3'd0);
  endtask

  // Verbosity filter at both ends, including levels beyond trace.
  task automatic test_level_filter();
    set_config(3'd7, 8'd10, 16'd1000);
    send_event(48'd1005, 3'd7);
    send_event(48'd1005, 3'd5);
    set_config(3'd0, 8'd10, 16'd1000);
    send_event(48'd1005, 3'd1);
    send_event(48'h5555_5555_5555, 3'd4);
    send_event(48'hAAAA_AAAA_AAAA, 3'd6);
    send_event(48'd1005, 3'd0);
  endtask

  // Tokens above a lowered burst, suppression, time going backward and the refill cap.
  task automatic test_suppression();
    set_config(3'd4, 8'd2, 16'hFFFF);
    repeat (6) send_event(48'd1005, 3'd2);
    send_event(48'd1000, 3'd2);
    send_event(48'd1005 + 48'd65535, 3'd3);
    send_event(48'd1005 + 48'd4 * 48'd65535, 3'd0);
  endtask

  // A burst of zero never yields a token; an interval of zero acts as one.
  task automatic test_burst_zero();
    set_config(3'd4, 8'd0, 16'd0);
    send_event(48'd263155, 3'd0);
    send_event(48'd263155, 3'd1);
  endtask

  task automatic test_random_traffic();
    logic [TW-1:0] cur_ms;
    logic [TW-1:0] t;
    logic [LEVEL_W-1:0] lv;
    logic [63:0] step;
    logic [63:0] ival;
    int roll;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(3'd4, 8'd1, 16'd0);
        1: set_config(3'd7, 8'd255, 16'hFFFF);
        2: set_config(3'd2, 8'd3, 16'd7);
        3: set_config(3'd1, 8'd255, 16'd1);
        default: begin
          set_config(3'($urandom_range(0, 7)),
                     ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(1, 20)),
                     16'($urandom_range(1, 300)));
          if (ph == 4) write_reg(REG_UNUSED, 16'hFFFF);
        end
      endcase
      set_idling(ph % 4);
      cur_ms = bucket_last_ms;
      ival = (shadow_ival == '0) ? 64'd1 : 64'(shadow_ival);
      repeat (63) begin
        roll = $urandom_range(0, 39);
        if (roll == 0) begin
          t = TW'({$urandom(), $urandom()});
        end else if (roll < 3) begin
          t = (cur_ms > 50) ? cur_ms - TW'($urandom_range(1, 50)) : cur_ms;
        end else if (roll < 16) begin
          t = cur_ms;
        end else begin
          step = 64'($urandom_range(0, 3 * int'(ival)));
          t = (64'(cur_ms) + step > 64'(TIME_MAX)) ? cur_ms : cur_ms + TW'(step);
        end
        if (t > cur_ms) cur_ms = t;
        lv = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        send_event(t, lv);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_event();
    test_level_filter();
    test_suppression();
    test_burst_zero();
    test_random_traffic();
    wait_drained();
    repeat (60) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000ns;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ltb_pkg.sv
rtl/ltb_div.sv
rtl/log_token_bucket_limiter_top.sv
rtl/ltb_checker.sv
tb/tb_log_token_bucket_limiter_top.sv
